// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the sidereal time block.
// Both macros expect a signal named clk in the enclosing module; LMST_ASSERT also expects rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define LMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define LMST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lmst_pkg.sv =====
// ---------------------------------------------------------------------------
// lmst_pkg
// Constants, types and calendar tables of the local mean sidereal time block.
// All scaled constants share the denominator 46080000000000 = 32*1440*10^9.
// ---------------------------------------------------------------------------
package lmst_pkg;

  // Fraction bits produced by the divider, and width of the result port
  localparam int FRAC_BITS  = 32;
  localparam int OUT_W      = 32;

  // Datapath widths
  localparam int NUM_W      = 54;   // numerator entering the divider
  localparam int REM_W      = 46;   // remainder, always below DENOM
  localparam int RED_STAGES = 9;    // subtracts DENOM<<8 .. DENOM<<0

  // Calendar limits
  localparam logic [11:0] EPOCH_YEAR = 12'd2025;
  localparam logic [11:0] LAST_YEAR  = 12'd2280;
  localparam logic [16:0] MAX_DAYS   = 17'd93501;  // 2280-12-31

  // Scaled constants
  localparam logic [REM_W-1:0] DENOM    = 46'd46080000000000;
  localparam logic [NUM_W-1:0] DENOM_N  = {{(NUM_W-REM_W){1'b0}}, DENOM};
  // base term plus two whole turns, so the sum never goes negative
  localparam logic [47:0]      BASE_OFS = 48'd105074981936640;
  // per day excess over a whole turn: DAY_MUL << DAY_SHIFT
  localparam logic [26:0]      DAY_MUL  = 27'd123205905;
  localparam int               DAY_SHIFT = 10;
  // per UT minute: TOD_MUL << TOD_SHIFT
  localparam logic [29:0]      TOD_MUL  = 30'd1002737909;
  localparam int               TOD_SHIFT = 5;
  // per longitude step of 1/65536 degree
  localparam logic [20:0]      LON_MUL  = 21'd1953125;

  // Control bits that travel with each pipeline slot
  typedef struct packed {
    logic vld;
    logic err;
  } lmst_ctl_t;

  // Days in the year before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] n;
    unique case (month)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Length of the month
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    unique case (month)
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/lmst_divider.sv =====
// ---------------------------------------------------------------------------
// lmst_divider
// Pipelined long division of the scaled sum by DENOM. The first stages
// strip whole turns, the rest produce one fraction bit each.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lmst_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  lmst_pkg::lmst_ctl_t         num_ctl,
  input  logic [lmst_pkg::NUM_W-1:0]  num,
  output lmst_pkg::lmst_ctl_t         frac_ctl,
  output logic [lmst_pkg::OUT_W-1:0]  frac
);

  // Turn reduction stages
  logic [lmst_pkg::NUM_W-1:0]     red_r     [lmst_pkg::RED_STAGES];
  lmst_pkg::lmst_ctl_t            red_ctl_r [lmst_pkg::RED_STAGES];

  // Last reduction stage, below one turn
  logic [lmst_pkg::NUM_W-1:0]     red_last;
  lmst_pkg::lmst_ctl_t            red_last_ctl;

  // Fraction stages (the last one writes the output registers)
  logic [lmst_pkg::REM_W-1:0]     frc_rem_r [lmst_pkg::FRAC_BITS-1];
  logic [lmst_pkg::FRAC_BITS-1:0] frc_q_r   [lmst_pkg::FRAC_BITS-1];
  lmst_pkg::lmst_ctl_t            frc_ctl_r [lmst_pkg::FRAC_BITS-1];

  logic [lmst_pkg::OUT_W-1:0]     frac_r;
  lmst_pkg::lmst_ctl_t            frac_ctl_r;

  // Subtract DENOM << (RED_STAGES-1-j) when it fits
  for (genvar j = 0; j < lmst_pkg::RED_STAGES; j++) begin : g_red
    logic [lmst_pkg::NUM_W-1:0] src;
    logic [lmst_pkg::NUM_W-1:0] dvs;
    lmst_pkg::lmst_ctl_t        src_ctl;

    if (j == 0) begin : g_head
      assign src     = num;
      assign src_ctl = num_ctl;
    end else begin : g_body
      assign src     = red_r[j-1];
      assign src_ctl = red_ctl_r[j-1];
    end

    assign dvs = lmst_pkg::DENOM_N << (lmst_pkg::RED_STAGES - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        red_ctl_r[j] <= '0;
      end else if (en) begin
        red_ctl_r[j] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        red_r[j] <= (src >= dvs) ? (src - dvs) : src;
      end
    end
  end

  assign red_last     = red_r[lmst_pkg::RED_STAGES-1];
  assign red_last_ctl = red_ctl_r[lmst_pkg::RED_STAGES-1];

  // Restoring division, one quotient bit per stage
  for (genvar i = 0; i < lmst_pkg::FRAC_BITS; i++) begin : g_frc
    logic [lmst_pkg::REM_W-1:0]     src_rem;
    logic [lmst_pkg::FRAC_BITS-1:0] src_q;
    lmst_pkg::lmst_ctl_t            src_ctl;
    logic [lmst_pkg::REM_W:0]       dbl;
    logic [lmst_pkg::REM_W:0]       dif;
    logic                           qbit;
    logic [lmst_pkg::FRAC_BITS-1:0] q_nxt;

    if (i == 0) begin : g_head
      assign src_rem = red_last[lmst_pkg::REM_W-1:0];
      assign src_q   = '0;
      assign src_ctl = red_last_ctl;
    end else begin : g_body
      assign src_rem = frc_rem_r[i-1];
      assign src_q   = frc_q_r[i-1];
      assign src_ctl = frc_ctl_r[i-1];
    end

    assign dbl   = {src_rem, 1'b0};
    assign dif   = dbl - {1'b0, lmst_pkg::DENOM};
    assign qbit  = (dbl >= {1'b0, lmst_pkg::DENOM});
    assign q_nxt = {src_q[lmst_pkg::FRAC_BITS-2:0], qbit};

    if (i < lmst_pkg::FRAC_BITS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          frc_ctl_r[i] <= '0;
        end else if (en) begin
          frc_ctl_r[i] <= src_ctl;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          frc_rem_r[i] <= qbit ? dif[lmst_pkg::REM_W-1:0] : dbl[lmst_pkg::REM_W-1:0];
          frc_q_r[i]   <= q_nxt;
        end
      end
    end else begin : g_last
      logic [lmst_pkg::OUT_W-1:0] aligned;

      // Bring the quotient to the 32-bit result scale
      if (lmst_pkg::FRAC_BITS >= lmst_pkg::OUT_W) begin : g_trunc
        assign aligned = q_nxt[lmst_pkg::FRAC_BITS-1 -: lmst_pkg::OUT_W];
      end else begin : g_pad
        assign aligned = {q_nxt, {(lmst_pkg::OUT_W-lmst_pkg::FRAC_BITS){1'b0}}};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          frac_ctl_r <= '0;
        end else if (en) begin
          frac_ctl_r <= src_ctl;
        end
      end

      // Flagged items leave with a zero fraction
      always_ff @(posedge clk) begin
        if (en) begin
          frac_r <= src_ctl.err ? '0 : aligned;
        end
      end
    end
  end

  assign frac     = frac_r;
  assign frac_ctl = frac_ctl_r;

  // Checks
  `LMST_ASSERT(a_turns_removed, red_last_ctl.vld |-> red_last < lmst_pkg::DENOM_N, "turns remain")
  `LMST_ASSERT(a_hold_on_stall, !en |=> $stable(frac) && $stable(frac_ctl), "stall not held")
  `LMST_ASSERT(a_error_zero, frac_ctl_r.vld && frac_ctl_r.err |-> frac_r == '0, "flagged nonzero")

endmodule

// ===== rtl/core/local_mean_sidereal_time_unit.sv =====
// ---------------------------------------------------------------------------
// local_mean_sidereal_time_unit
// Local mean sidereal time of a civil timestamp as a 32-bit day fraction.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel in_*: one timestamp per transaction (year, month, day,
//    hour, minute, whole-hour zone, longitude in 1/65536 degree).
//  - Output channel out_*: one result per input transaction, in order, with
//    out_input_error set and a zero fraction for out-of-range date/time/zone.
//  - From acceptance to out_valid the pipeline has four stages for the day
//    count, the three products and two adds, then a 41-stage long division
//    (9 stages strip whole turns, 32 give one fraction bit each).
//  - Throughput is one transaction per cycle while out_ready is high.
//  - When a result waits with out_ready low the whole pipeline holds and
//    in_ready drops; nothing is lost or repeated. A free output slot lets
//    the pipeline move and in_ready rise again.
//  - Synchronous active-low reset empties every stage; no configuration
//    and no state carry over between transactions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module local_mean_sidereal_time_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [11:0]         in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  input  logic [4:0]          in_hour,
  input  logic [5:0]          in_minute,
  input  logic signed [4:0]   in_zone_hours,
  input  logic signed [24:0]  in_longitude,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_sidereal_fraction,
  output logic                out_input_error
);

  logic                             en;
  lmst_pkg::lmst_ctl_t              frac_ctl;
  logic [lmst_pkg::OUT_W-1:0]       frac;

  // Stage 1: checks, day count, UT minute of day
  logic [11:0]                      ydiff;
  logic [7:0]                       yofs;
  logic [5:0]                       leaps;
  logic                             leap;
  logic                             leap_adj;
  logic                             err_nxt;
  logic [16:0]                      days_nxt;
  logic signed [12:0]               hz;
  logic signed [12:0]               tod_nxt;

  lmst_pkg::lmst_ctl_t              s1_ctl_r;
  logic [16:0]                      s1_days_r;
  logic signed [12:0]               s1_tod_r;
  logic signed [24:0]               s1_lon_r;

  // Stage 2: products
  lmst_pkg::lmst_ctl_t              s2_ctl_r;
  logic [43:0]                      s2_pd_r;
  logic signed [42:0]               s2_pt_r;
  logic signed [45:0]               s2_pl_r;

  // Stage 3: base, minute and longitude terms
  lmst_pkg::lmst_ctl_t              s3_ctl_r;
  logic [47:0]                      s3_sum_r;
  logic [43:0]                      s3_pd_r;

  // Stage 4: full numerator
  lmst_pkg::lmst_ctl_t              s4_ctl_r;
  logic [lmst_pkg::NUM_W-1:0]       s4_num_r;

  // Whole pipeline moves unless a finished result is held
  assign en       = !frac_ctl.vld || out_ready;
  assign in_ready = en;

  // Calendar: years since the epoch, leap days before this year
  always_comb begin
    ydiff    = in_year - lmst_pkg::EPOCH_YEAR;
    yofs     = ydiff[7:0];
    leaps    = yofs[7:2] - 6'(yofs >= 8'd76) - 6'(yofs >= 8'd176);
    leap     = (in_year[1:0] == 2'b00) && (in_year != 12'd2100) && (in_year != 12'd2200);
    leap_adj = (in_month > 4'd2) && leap;
    days_nxt = 17'(yofs) * 17'd365 + 17'(leaps) + 17'(lmst_pkg::days_before(in_month))
             + 17'(leap_adj) + 17'(in_day) - 17'd1;
  end

  // Range checks
  always_comb begin
    err_nxt = (in_year < lmst_pkg::EPOCH_YEAR) || (in_year > lmst_pkg::LAST_YEAR)
           || (in_month == 4'd0) || (in_month > 4'd12)
           || (in_hour > 5'd23) || (in_minute > 6'd59)
           || (in_zone_hours < -5'sd12) || (in_zone_hours > 5'sd14)
           || (in_day == 5'd0) || (in_day > lmst_pkg::month_len(in_month, leap));
  end

  // UT minute of the day, may fall below zero or past one day
  always_comb begin
    hz      = $signed({8'b0, in_hour}) - $signed({{8{in_zone_hours[4]}}, in_zone_hours});
    tod_nxt = hz * 13'sd60 + $signed({7'b0, in_minute});
  end

  // Control registers of stages 1..4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= '{vld: in_valid, err: err_nxt};
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  // Datapath registers of stages 1..4
  always_ff @(posedge clk) begin
    if (en) begin
      s1_days_r <= days_nxt;
      s1_tod_r  <= tod_nxt;
      s1_lon_r  <= in_longitude;

      s2_pd_r   <= 44'(s1_days_r) * 44'(lmst_pkg::DAY_MUL);
      s2_pt_r   <= 43'(s1_tod_r) * $signed(43'(lmst_pkg::TOD_MUL));
      s2_pl_r   <= 46'(s1_lon_r) * $signed(46'(lmst_pkg::LON_MUL));

      // sum lies in [0, 2^48) for every input pattern
      s3_sum_r  <= lmst_pkg::BASE_OFS + {s2_pt_r, {lmst_pkg::TOD_SHIFT{1'b0}}} + 48'(s2_pl_r);
      s3_pd_r   <= s2_pd_r;

      s4_num_r  <= 54'(s3_sum_r) + {s3_pd_r, {lmst_pkg::DAY_SHIFT{1'b0}}};
    end
  end

  lmst_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .num_ctl  (s4_ctl_r),
    .num      (s4_num_r),
    .frac_ctl (frac_ctl),
    .frac     (frac)
  );

  assign out_valid             = frac_ctl.vld;
  assign out_input_error       = frac_ctl.err;
  assign out_sidereal_fraction = frac;

  // Checks
  `LMST_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")
  `LMST_ASSERT(a_error_zero, out_valid && out_input_error |-> out_sidereal_fraction == '0, "flagged result carries a nonzero fraction")
  `LMST_ASSERT(a_day_bound, s1_ctl_r.vld && !s1_ctl_r.err |-> s1_days_r <= lmst_pkg::MAX_DAYS, "day count beyond the last supported date")

endmodule
